[rtl/rc4_pkg.sv]
package rc4_pkg;

   // Byte and permutation geometry.
   localparam int BYTE_W        = 8;
   localparam int PERM_DEPTH    = 256;
   localparam int PERM_AW       = 8;
   localparam int MAX_KEY_BYTES = 256;
   localparam int KEY_CNT_W     = 9;

   // Item operation codes.
   localparam logic OP_KEY  = 1'b0;
   localparam logic OP_DATA = 1'b1;

   // Controller states.
   typedef enum logic [3:0] {
      ST_INIT_RESET,
      ST_IDLE,
      ST_DATA_J,
      ST_DATA_SWAP,
      ST_DATA_OUT,
      ST_INIT_SCHED,
      ST_KSA_READ,
      ST_KSA_J,
      ST_KSA_SWAP,
      ST_KSA_END
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept_data;
      logic store_key;
      logic sched_start;
      logic init_write;
      logic ksa_read;
      logic ksa_j;
      logic data_j;
      logic swap_lo;
      logic ksa_end;
      logic data_end;
      logic sched_done;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic i_last;
      logic out_busy;
   } status_type;

endpackage

[rtl/rc4_req_if.sv]
interface rc4_req_if;
   import rc4_pkg::*;

   logic              valid;
   logic              ready;
   logic              op;
   logic [BYTE_W-1:0] byte_in;
   logic              last;

   modport source (output valid, output op, output byte_in, output last, input ready);
   modport sink   (input valid, input op, input byte_in, input last, output ready);
endinterface

[rtl/rc4_rsp_if.sv]
interface rc4_rsp_if;
   import rc4_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] byte_out;

   modport source (output valid, output byte_out, input ready);
   modport sink   (input valid, input byte_out, output ready);
endinterface

[rtl/rc4_datapath.sv]
module rc4_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  rc4_pkg::cmd_type            cmd,
   output rc4_pkg::status_type         status,
   input  logic [rc4_pkg::BYTE_W-1:0]  byte_in,
   rc4_rsp_if.source                   rsp
);
   import rc4_pkg::*;

   // Permutation and key store memories.
   logic [BYTE_W-1:0] perm_mem [PERM_DEPTH];
   logic [BYTE_W-1:0] key_mem  [PERM_DEPTH];

   // Indices and counters. The index i also serves as the sweep counter of the
   // key schedule, and j as its running sum, so both end the schedule at zero.
   logic [PERM_AW-1:0]   i_ff;
   logic [PERM_AW-1:0]   j_ff;
   logic [PERM_AW-1:0]   kpos_ff;
   logic [KEY_CNT_W-1:0] key_count_ff;

   // Working registers.
   logic [BYTE_W-1:0]  a_ff;
   logic [BYTE_W-1:0]  c_ff;
   logic [PERM_AW-1:0] t_ff;
   logic [BYTE_W-1:0]  byte_ff;
   logic [BYTE_W-1:0]  rd_a_ff;
   logic [BYTE_W-1:0]  rd_b_ff;
   logic [BYTE_W-1:0]  rd_k_ff;
   logic [BYTE_W-1:0]  out_byte_ff;
   logic               out_valid_ff;

   // Memory port controls.
   logic               perm_we;
   logic [PERM_AW-1:0] perm_waddr;
   logic [BYTE_W-1:0]  perm_wdata;
   logic               re_a;
   logic [PERM_AW-1:0] addr_a;
   logic               re_b;
   logic [PERM_AW-1:0] addr_b;
   logic               key_we;

   logic [PERM_AW-1:0]   j_step;
   logic [KEY_CNT_W-1:0] klen;
   logic                 kpos_wrap;
   logic [BYTE_W-1:0]    ks;

   // Next j: plus S[i] for a data byte, plus S[i] and a key byte in the schedule.
   assign j_step = j_ff + rd_a_ff + (cmd.ksa_j ? rd_k_ff : '0);

   // Effective key length; the key position wraps at it.
   assign klen      = (key_count_ff == '0) ? KEY_CNT_W'(1) : key_count_ff;
   assign kpos_wrap = ({1'b0, kpos_ff} + KEY_CNT_W'(1)) >= klen;

   assign key_we = cmd.store_key && (key_count_ff < KEY_CNT_W'(MAX_KEY_BYTES));

   // Keystream byte S[a+c] after the swap: the read was taken before the
   // swap had written both entries, so the swapped entries are forwarded.
   assign ks = (t_ff == j_ff) ? a_ff : ((t_ff == i_ff) ? c_ff : rd_a_ff);

   // Permutation port selection for each command.
   always_comb begin
      perm_we    = 1'b0;
      perm_waddr = i_ff;
      perm_wdata = a_ff;
      re_a       = 1'b0;
      addr_a     = i_ff;
      re_b       = 1'b0;
      addr_b     = j_step;
      if (cmd.accept_data) begin
         re_a   = 1'b1;
         addr_a = i_ff + PERM_AW'(1);
      end
      if (cmd.init_write) begin
         perm_we    = 1'b1;
         perm_waddr = i_ff;
         perm_wdata = i_ff;
      end
      if (cmd.ksa_read) begin
         re_a   = 1'b1;
         addr_a = i_ff;
      end
      if (cmd.data_j || cmd.ksa_j) begin
         re_b   = 1'b1;
         addr_b = j_step;
      end
      if (cmd.swap_lo) begin
         perm_we    = 1'b1;
         perm_waddr = i_ff;
         perm_wdata = rd_b_ff;
         re_a       = 1'b1;
         addr_a     = a_ff + rd_b_ff;
      end
      if (cmd.ksa_end || cmd.data_end) begin
         perm_we    = 1'b1;
         perm_waddr = j_ff;
         perm_wdata = a_ff;
      end
   end

   // Permutation memory: one write port, two registered read ports.
   always_ff @(posedge clock) begin
      if (perm_we) begin
         perm_mem[perm_waddr] <= perm_wdata;
      end
      if (re_a) begin
         rd_a_ff <= perm_mem[addr_a];
      end
      if (re_b) begin
         rd_b_ff <= perm_mem[addr_b];
      end
   end

   // Key store: written in arrival order, read at the key position.
   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[key_count_ff[PERM_AW-1:0]] <= byte_in;
      end
      if (cmd.ksa_read) begin
         rd_k_ff <= key_mem[kpos_ff];
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         i_ff         <= '0;
         j_ff         <= '0;
         kpos_ff      <= '0;
         key_count_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd.accept_data || cmd.init_write) begin
            i_ff <= i_ff + PERM_AW'(1);
         end
         // The last swap step also returns the key position to zero.
         if (cmd.ksa_end) begin
            i_ff    <= i_ff + PERM_AW'(1);
            kpos_ff <= (kpos_wrap || cmd.sched_done) ? '0 : kpos_ff + PERM_AW'(1);
         end
         if (cmd.data_j || cmd.ksa_j) begin
            j_ff <= j_step;
         end
         if (key_we) begin
            key_count_ff <= key_count_ff + KEY_CNT_W'(1);
         end
         if (cmd.sched_start) begin
            i_ff <= '0;
            j_ff <= '0;
         end
         if (cmd.sched_done) begin
            j_ff         <= '0;
            key_count_ff <= '0;
         end
         if (cmd.data_end) begin
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.accept_data) begin
         byte_ff <= byte_in;
      end
      if (cmd.data_j || cmd.ksa_j) begin
         a_ff <= rd_a_ff;
      end
      if (cmd.swap_lo) begin
         c_ff <= rd_b_ff;
         t_ff <= a_ff + rd_b_ff;
      end
      if (cmd.data_end) begin
         out_byte_ff <= byte_ff ^ ks;
      end
   end

   assign status.i_last   = (i_ff == PERM_AW'(PERM_DEPTH - 1));
   assign status.out_busy = out_valid_ff && !rsp.ready;

   assign rsp.valid    = out_valid_ff;
   assign rsp.byte_out = out_byte_ff;

endmodule

[rtl/rc4_controller.sv]
module rc4_controller (
   input  logic                clock,
   input  logic                reset,
   rc4_req_if.sink             req,
   input  rc4_pkg::status_type status,
   output rc4_pkg::cmd_type    cmd
);
   import rc4_pkg::*;

   state_type state_ff;
   state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT_RESET;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req.ready = 1'b0;
      case (state_ff)
         ST_INIT_RESET: begin
            cmd.init_write = 1'b1;
            if (status.i_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               if (req.op == OP_DATA) begin
                  cmd.accept_data = 1'b1;
                  state_in        = ST_DATA_J;
               end else begin
                  cmd.store_key = 1'b1;
                  if (req.last) begin
                     cmd.sched_start = 1'b1;
                     state_in        = ST_INIT_SCHED;
                  end
               end
            end
         end
         ST_DATA_J: begin
            cmd.data_j = 1'b1;
            state_in   = ST_DATA_SWAP;
         end
         ST_DATA_SWAP: begin
            cmd.swap_lo = 1'b1;
            state_in    = ST_DATA_OUT;
         end
         ST_DATA_OUT: begin
            // Wait here while the output register still holds an untaken byte.
            if (!status.out_busy) begin
               cmd.data_end = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_INIT_SCHED: begin
            cmd.init_write = 1'b1;
            if (status.i_last) begin
               state_in = ST_KSA_READ;
            end
         end
         ST_KSA_READ: begin
            cmd.ksa_read = 1'b1;
            state_in     = ST_KSA_J;
         end
         ST_KSA_J: begin
            cmd.ksa_j = 1'b1;
            state_in  = ST_KSA_SWAP;
         end
         ST_KSA_SWAP: begin
            cmd.swap_lo = 1'b1;
            state_in    = ST_KSA_END;
         end
         ST_KSA_END: begin
            cmd.ksa_end = 1'b1;
            if (status.i_last) begin
               cmd.sched_done = 1'b1;
               state_in       = ST_IDLE;
            end else begin
               state_in = ST_KSA_READ;
            end
         end
         default: begin
            state_in = ST_INIT_RESET;
         end
      endcase
   end

endmodule

[rtl/rc4_stream_cipher_core.sv]
// Data byte: the result passes DATA_J, DATA_SWAP and DATA_OUT before it is valid, and
// no new byte is taken until then, set by the dependent permutation reads and the two
// swap writes on one write port. Key byte: input stays open. Final key byte: schedule
// of 256 identity writes, then 256 swap steps (KSA_READ, KSA_J, KSA_SWAP, KSA_END),
// before the next transfer is taken. Reset (synchronous, active high) clears indices
// and key count, then runs an identity pass over perm_mem while no input is taken.
module rc4_stream_cipher_core (
   input  logic      clock,
   input  logic      reset,
   rc4_req_if.sink   req_ch,
   rc4_rsp_if.source rsp_ch
);
   import rc4_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Sequencer.
   rc4_controller u_controller (
      .clock  (clock),
      .reset  (reset),
      .req    (req_ch),
      .status (status),
      .cmd    (cmd)
   );

   // Memories, indices and output register.
   rc4_datapath u_datapath (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .status  (status),
      .byte_in (req_ch.byte_in),
      .rsp     (rsp_ch)
   );

`ifndef ASSERT_OFF
   // The identity pass after reset blocks input.
   a_reset_blocks: assert property (@(posedge clock) reset |=> !req_ch.ready)
      else $error("input taken right after reset");

   // A final key byte starts the schedule, which blocks input.
   a_sched_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready && req_ch.op == OP_KEY && req_ch.last)
      |=> !req_ch.ready)
      else $error("input taken during key schedule");

   // A data byte keeps the input closed while the keystream step runs.
   a_data_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready && req_ch.op == OP_DATA)
      |=> !req_ch.ready ##1 !req_ch.ready)
      else $error("input taken during keystream step");
`endif

endmodule
